>>> rtl/sbpq_pkg.sv
package sbpq_pkg;

  localparam int DATA_BINS = 8;
  localparam int BIN_DEPTH = 64;
  localparam int LARGE_PACKET_BYTES = 1460;

  localparam int NBINS = DATA_BINS + 1;
  localparam int NENTRIES = NBINS * BIN_DEPTH;
  localparam int BIN_W = $clog2(NBINS);
  localparam int OFF_W = $clog2(BIN_DEPTH);
  localparam int CNT_W = $clog2(BIN_DEPTH + 1);
  localparam int ADDR_W = $clog2(NENTRIES);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 40;

  // Descriptor word: id, arrival slack, size, enqueue time.
  localparam int ENTRY_W = 12 + 40 + 16 + 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TX_COST   = 3'd0,
    CFG_BOUND     = 3'd1,
    CFG_CAPACITY  = 3'd2,
    CFG_CTRL_EN   = 3'd3,
    CFG_CTRL_END  = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    KIND_ENQ     = 3'd0,
    KIND_ENQ_DROP = 3'd1,
    KIND_DEQ     = 3'd2,
    KIND_EMPTY   = 3'd3,
    KIND_REFUSED = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COST,
    ST_CLASSIFY,
    ST_READ,
    ST_WRITE,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [11:0] id;
    logic [39:0] slack;
    logic [15:0] size;
    logic [39:0] tstamp;
  } entry_t;

  typedef struct packed {
    logic        opcode;
    logic [11:0] packet_id;
    logic [39:0] slack_in;
    logic [15:0] size_bytes;
    logic [39:0] now_time;
  } req_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [11:0] packet_id_out;
    logic [39:0] slack_out;
    logic [15:0] size_out;
    logic [3:0]  bin_index;
    logic [25:0] total_bytes;
  } resp_t;

endpackage

>>> rtl/sbpq_if.sv
interface sbpq_req_if (input logic clk);
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [11:0]         packet_id;
  logic signed [39:0]  slack_in;
  logic [15:0]         size_bytes;
  logic [39:0]         now_time;
  modport source (output valid, opcode, packet_id, slack_in, size_bytes, now_time,
                  input ready);
  modport sink (input valid, opcode, packet_id, slack_in, size_bytes, now_time,
                output ready);
endinterface

interface sbpq_resp_if (input logic clk);
  logic                valid;
  logic                ready;
  logic [2:0]          result_kind;
  logic [11:0]         packet_id_out;
  logic signed [39:0]  slack_out;
  logic [15:0]         size_out;
  logic [3:0]          bin_index;
  logic [25:0]         total_bytes;
  modport source (output valid, result_kind, packet_id_out, slack_out, size_out,
                  bin_index, total_bytes, input ready);
  modport sink (input valid, result_kind, packet_id_out, slack_out, size_out,
                bin_index, total_bytes, output ready);
endinterface

>>> rtl/sbpq_ram.sv
module sbpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/sbpq_ctrl.sv
module sbpq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sbpq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sbpq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sbpq_pkg::req_t                 req,
  output logic                           out_valid,
  input  logic                           out_ready,
  output sbpq_pkg::resp_t                resp,
  output logic                           mem_we,
  output logic [sbpq_pkg::ADDR_W-1:0]    mem_waddr,
  output sbpq_pkg::entry_t               mem_wdata,
  output logic [sbpq_pkg::ADDR_W-1:0]    mem_raddr,
  input  sbpq_pkg::entry_t               mem_rdata
);
  localparam int NB = sbpq_pkg::NBINS;
  localparam int BW = sbpq_pkg::BIN_W;
  localparam int OW = sbpq_pkg::OFF_W;
  localparam int CW = sbpq_pkg::CNT_W;
  localparam int AW = sbpq_pkg::ADDR_W;

  // Configuration registers.
  logic [23:0] tx_cost;
  logic [39:0] bound_step;
  logic [6:0]  bin_cap;
  logic        ctrl_en;
  logic [39:0] ctrl_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_cost    <= 24'd52429;
      bound_step <= 40'd125000000;
      bin_cap    <= 7'd64;
      ctrl_en    <= 1'b0;
      ctrl_end   <= '0;
    end else if (cfg_we) begin
      case (sbpq_pkg::cfg_idx_t'(cfg_index))
        sbpq_pkg::CFG_TX_COST:  tx_cost    <= cfg_data[23:0];
        sbpq_pkg::CFG_BOUND:    bound_step <= cfg_data[39:0];
        sbpq_pkg::CFG_CAPACITY: bin_cap    <= cfg_data[6:0];
        sbpq_pkg::CFG_CTRL_EN:  ctrl_en    <= cfg_data[0];
        sbpq_pkg::CFG_CTRL_END: ctrl_end   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  // Per-bin bookkeeping, small enough for flip-flops.
  logic [OW-1:0] bin_head [NB];
  logic [CW-1:0] bin_count [NB];
  logic [25:0]   held_bytes;

  sbpq_pkg::state_t state, state_next;
  sbpq_pkg::req_t   rq;
  logic [39:0]      cost;
  logic [BW-1:0]    sel_bin;
  logic             drop;
  logic             is_enq_ok;
  logic [OW-1:0]    wr_off;
  sbpq_pkg::resp_t  resp_q;
  sbpq_pkg::resp_t  resp_pend;
  sbpq_pkg::resp_t  resp_next;
  logic [25:0]      held_next;

  // Effective capacity, clamped to 1..BIN_DEPTH.
  logic [CW-1:0] cap_eff;
  always_comb begin
    if (bin_cap == 7'd0) begin
      cap_eff = CW'(1);
    end else if (32'(bin_cap) > sbpq_pkg::BIN_DEPTH) begin
      cap_eff = CW'(sbpq_pkg::BIN_DEPTH);
    end else begin
      cap_eff = CW'(bin_cap);
    end
  end

  // Signed sum of arrival slack and cost, 42 bits.
  logic signed [41:0] cur;
  assign cur = $signed({{2{rq.slack_in[39]}}, rq.slack_in}) + $signed({2'b00, cost});

  // Bin search: one bound compare per cycle with a running bound.
  logic [45:0] bound_acc;
  logic        bound_below;
  assign bound_below = $signed({2'b00, bound_acc[39:0]}) < cur && bound_acc[45:40] == '0;

  // Lowest non-empty bin for dequeue.
  logic [BW-1:0] deq_bin;
  logic          any_nonempty;
  always_comb begin
    deq_bin = '0;
    any_nonempty = 1'b0;
    for (int i = NB - 1; i >= 0; i--) begin
      if (bin_count[i] != '0) begin
        deq_bin = BW'(i);
        any_nonempty = 1'b1;
      end
    end
  end

  logic ctrl_route;
  assign ctrl_route = ctrl_en && (32'(rq.size_bytes) < sbpq_pkg::LARGE_PACKET_BYTES) &&
                      (rq.now_time < ctrl_end);

  logic [OW-1:0] head_sel;
  logic [CW-1:0] cnt_sel;
  assign head_sel = bin_head[sel_bin];
  assign cnt_sel  = bin_count[sel_bin];

  function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                               input logic [OW-1:0] off);
    slot_addr = AW'(32'(b) * sbpq_pkg::BIN_DEPTH + 32'(off));
  endfunction

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sbpq_pkg::ST_IDLE:     if (in_valid) state_next = sbpq_pkg::ST_COST;
      sbpq_pkg::ST_COST:     state_next = rq.opcode ? sbpq_pkg::ST_READ
                                                    : sbpq_pkg::ST_CLASSIFY;
      sbpq_pkg::ST_CLASSIFY: begin
        if (ctrl_route || !(32'(sel_bin) < sbpq_pkg::DATA_BINS && bound_below)) begin
          state_next = sbpq_pkg::ST_READ;
        end
      end
      sbpq_pkg::ST_READ:     state_next = sbpq_pkg::ST_WRITE;
      sbpq_pkg::ST_WRITE:    state_next = sbpq_pkg::ST_OUT;
      sbpq_pkg::ST_OUT:      if (!out_valid || out_ready) state_next = sbpq_pkg::ST_IDLE;
      default:               state_next = sbpq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_ready  = 1'b0;
    mem_raddr = slot_addr(sel_bin, head_sel);
    mem_we    = 1'b0;
    mem_waddr = slot_addr(sel_bin, wr_off);
    mem_wdata = '{id: rq.packet_id, slack: rq.slack_in, size: rq.size_bytes,
                  tstamp: rq.now_time};
    unique case (state)
      sbpq_pkg::ST_IDLE:  in_ready = 1'b1;
      sbpq_pkg::ST_READ:  mem_raddr = rq.opcode ? slot_addr(sel_bin, head_sel)
                                                : slot_addr(sel_bin, OW'(head_sel + OW'(cnt_sel - CW'(1))));
      sbpq_pkg::ST_WRITE: mem_we = is_enq_ok;
      default: ;
    endcase
  end

  // Waiting-time deduction with saturation.
  logic signed [42:0] deq_slack;
  assign deq_slack = $signed({{3{mem_rdata.slack[39]}}, mem_rdata.slack}) -
                     ($signed({3'b000, rq.now_time}) - $signed({3'b000, mem_rdata.tstamp}));
  logic [39:0] deq_slack_sat;
  always_comb begin
    if (deq_slack > 43'sd549755813887) begin
      deq_slack_sat = 40'h7F_FFFF_FFFF;
    end else if (deq_slack < -43'sd549755813888) begin
      deq_slack_sat = 40'h80_0000_0000;
    end else begin
      deq_slack_sat = deq_slack[39:0];
    end
  end

  // Result of the item in the write-back cycle.
  always_comb begin
    resp_next = '0;
    held_next = held_bytes;
    if (!rq.opcode) begin
      if (!is_enq_ok) begin
        resp_next.result_kind = sbpq_pkg::KIND_REFUSED;
      end else if (drop) begin
        resp_next.result_kind   = sbpq_pkg::KIND_ENQ_DROP;
        resp_next.packet_id_out = mem_rdata.id;
        resp_next.size_out      = mem_rdata.size;
        resp_next.bin_index     = 4'(sel_bin);
        held_next = held_bytes - 26'(mem_rdata.size) + 26'(rq.size_bytes);
      end else begin
        resp_next.result_kind = sbpq_pkg::KIND_ENQ;
        resp_next.bin_index   = 4'(sel_bin);
        held_next = held_bytes + 26'(rq.size_bytes);
      end
    end else if (!any_nonempty) begin
      resp_next.result_kind = sbpq_pkg::KIND_EMPTY;
    end else begin
      resp_next.result_kind   = sbpq_pkg::KIND_DEQ;
      resp_next.packet_id_out = mem_rdata.id;
      resp_next.slack_out     = (sel_bin == '0) ? mem_rdata.slack : deq_slack_sat;
      resp_next.size_out      = mem_rdata.size;
      resp_next.bin_index     = 4'(sel_bin);
      held_next = held_bytes - 26'(mem_rdata.size);
    end
    resp_next.total_bytes = held_next;
  end

  logic out_v;
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sbpq_pkg::ST_IDLE;
      out_v      <= 1'b0;
      held_bytes <= '0;
      for (int i = 0; i < NB; i++) begin
        bin_head[i]  <= '0;
        bin_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == sbpq_pkg::ST_OUT && (!out_v || out_ready)) begin
        out_v <= 1'b1;
      end else if (out_ready) begin
        out_v <= 1'b0;
      end
      unique case (state)
        sbpq_pkg::ST_IDLE: begin
          if (in_valid) begin
            rq <= req;
          end
        end
        sbpq_pkg::ST_COST: begin
          cost      <= 40'((({24'd0, rq.size_bytes}) * {16'd0, tx_cost}) >> 16);
          sel_bin   <= rq.opcode ? deq_bin : BW'(1);
          bound_acc <= {6'd0, bound_step};
          drop      <= 1'b0;
          is_enq_ok <= 1'b0;
        end
        sbpq_pkg::ST_CLASSIFY: begin
          if (ctrl_route) begin
            sel_bin <= '0;
          end else if (32'(sel_bin) < sbpq_pkg::DATA_BINS && bound_below) begin
            sel_bin   <= sel_bin + BW'(1);
            bound_acc <= bound_acc + {6'd0, bound_step};
          end
        end
        sbpq_pkg::ST_READ: begin
          if (!rq.opcode) begin
            if (sel_bin == '0) begin
              is_enq_ok <= 32'(cnt_sel) < sbpq_pkg::BIN_DEPTH;
              wr_off    <= OW'(head_sel + OW'(cnt_sel));
            end else begin
              is_enq_ok <= 1'b1;
              drop      <= cnt_sel >= cap_eff;
              wr_off    <= (cnt_sel >= cap_eff) ? OW'(head_sel + OW'(cnt_sel - CW'(1)))
                                                : OW'(head_sel + OW'(cnt_sel));
            end
          end
        end
        sbpq_pkg::ST_WRITE: begin
          resp_pend  <= resp_next;
          held_bytes <= held_next;
          if (!rq.opcode) begin
            if (is_enq_ok && !drop) begin
              bin_count[sel_bin] <= cnt_sel + CW'(1);
            end
          end else if (any_nonempty) begin
            bin_count[sel_bin] <= cnt_sel - CW'(1);
            bin_head[sel_bin]  <= OW'(head_sel + OW'(1));
          end
        end
        sbpq_pkg::ST_OUT: begin
          // The result moves on only once the output register is free.
          if (!out_v || out_ready) resp_q <= resp_pend;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_v;
  assign resp = resp_q;
endmodule

>>> rtl/slack_binned_priority_queue.sv
// Channel  Dir  Handshake      Payload
// req      in   valid/ready    opcode, packet_id, slack_in, size_bytes, now_time
// resp     out  valid/ready    result_kind, packet_id_out, slack_out, size_out,
//                              bin_index, total_bytes
// cfg      in   cfg_we         cfg_index, cfg_data
// One item at a time. A dequeue passes through the cost, read, write-back and output
// states; an enqueue also runs a bin search before the read, one bin at a time.
// Synchronous active-high reset clears the bin pointers and counts; the descriptor
// memory is not cleared. A stalled result holds in the output register while the
// next item runs up to its result stage and waits there until the register is free.
module slack_binned_priority_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sbpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbpq_pkg::CFG_DATA_W-1:0] cfg_data,
  sbpq_req_if.sink                        req,
  sbpq_resp_if.source                     resp
);
  sbpq_pkg::req_t   rq;
  sbpq_pkg::resp_t  rs;
  sbpq_pkg::entry_t wdata, rdata;
  logic             we;
  logic [sbpq_pkg::ADDR_W-1:0] waddr, raddr;

  assign rq = '{opcode: req.opcode, packet_id: req.packet_id, slack_in: req.slack_in,
                size_bytes: req.size_bytes, now_time: req.now_time};

  sbpq_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid(req.valid), .in_ready(req.ready), .req(rq),
    .out_valid(resp.valid), .out_ready(resp.ready), .resp(rs),
    .mem_we(we), .mem_waddr(waddr), .mem_wdata(wdata),
    .mem_raddr(raddr), .mem_rdata(rdata)
  );

  sbpq_ram #(.WIDTH(sbpq_pkg::ENTRY_W), .DEPTH(sbpq_pkg::NENTRIES)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign resp.result_kind   = rs.result_kind;
  assign resp.packet_id_out = rs.packet_id_out;
  assign resp.slack_out     = rs.slack_out;
  assign resp.size_out      = rs.size_out;
  assign resp.bin_index     = rs.bin_index;
  assign resp.total_bytes   = rs.total_bytes;
endmodule

>>> bench/slack_binned_priority_queue_tb.sv
module slack_binned_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam longint SLACK_MAX = 64'sd549755813887;
  localparam longint SLACK_MIN = -64'sd549755813888;

  class slack_queue_scoreboard;
    logic [23:0] tx_cost;
    logic [39:0] bound;
    logic [6:0]  capacity;
    logic        ctrl_en;
    logic [39:0] ctrl_end;
    logic [11:0] ent_id[NBINS][BIN_DEPTH];
    logic [39:0] ent_slack[NBINS][BIN_DEPTH];
    logic [15:0] ent_size[NBINS][BIN_DEPTH];
    logic [39:0] ent_time[NBINS][BIN_DEPTH];
    int head[NBINS];
    int count[NBINS];
    int held;
    int errors;
    resp_t expected_results[$];

    function new();
      tx_cost = 24'd52429;
      bound = 40'd125000000;
      capacity = 7'd64;
      ctrl_en = 1'b0;
      ctrl_end = '0;
      foreach (head[i]) begin
        head[i] = 0;
        count[i] = 0;
      end
      held = 0;
      errors = 0;
    endfunction

    function void apply_reg(cfg_idx_t idx, logic [39:0] v);
      case (idx)
        CFG_TX_COST:  tx_cost = v[23:0];
        CFG_BOUND:    bound = v;
        CFG_CAPACITY: capacity = v[6:0];
        CFG_CTRL_EN:  ctrl_en = v[0];
        CFG_CTRL_END: ctrl_end = v;
        default: ;
      endcase
    endfunction

    function void note_request(req_t r);
      resp_t e;
      longint cost, cur, sl, waited;
      int b, cap, pos;
      e = '0;
      if (r.opcode == 1'b0) begin
        cost = longint'((64'(r.size_bytes) * 64'(tx_cost)) >> 16);
        cur = longint'($signed(r.slack_in)) + cost;
        if (ctrl_en && r.size_bytes < LARGE_PACKET_BYTES && r.now_time < ctrl_end) begin
          b = 0;
          if (count[0] >= BIN_DEPTH) begin
            e.result_kind = KIND_REFUSED;
            e.total_bytes = held[25:0];
            expected_results.push_back(e);
            return;
          end
        end else begin
          b = 1;
          while (b < DATA_BINS && longint'(bound) * b < cur) b++;
          cap = int'(capacity);
          if (cap < 1) cap = 1;
          if (cap > BIN_DEPTH) cap = BIN_DEPTH;
          // A full bin gives up its newest packet to make room.
          if (count[b] >= cap) begin
            pos = (head[b] + count[b] - 1) % BIN_DEPTH;
            e.result_kind = KIND_ENQ_DROP;
            e.packet_id_out = ent_id[b][pos];
            e.size_out = ent_size[b][pos];
            count[b]--;
            held -= int'(ent_size[b][pos]);
          end
        end
        pos = (head[b] + count[b]) % BIN_DEPTH;
        ent_id[b][pos] = r.packet_id;
        ent_slack[b][pos] = r.slack_in;
        ent_size[b][pos] = r.size_bytes;
        ent_time[b][pos] = r.now_time;
        count[b]++;
        held += int'(r.size_bytes);
        e.bin_index = 4'(b);
      end else begin
        b = 0;
        if (count[0] == 0) begin
          b = 1;
          while (b <= DATA_BINS && count[b] == 0) b++;
        end
        if (b > DATA_BINS) begin
          e.result_kind = KIND_EMPTY;
        end else begin
          pos = head[b];
          sl = longint'($signed(ent_slack[b][pos]));
          if (b != 0) begin
            waited = longint'(r.now_time) - longint'(ent_time[b][pos]);
            sl -= waited;
            if (sl > SLACK_MAX) sl = SLACK_MAX;
            if (sl < SLACK_MIN) sl = SLACK_MIN;
          end
          head[b] = (head[b] + 1) % BIN_DEPTH;
          count[b]--;
          held -= int'(ent_size[b][pos]);
          e.result_kind = KIND_DEQ;
          e.packet_id_out = ent_id[b][pos];
          e.slack_out = sl[39:0];
          e.size_out = ent_size[b][pos];
          e.bin_index = 4'(b);
        end
      end
      e.total_bytes = held[25:0];
      expected_results.push_back(e);
    endfunction

    function void check_result(resp_t a);
      resp_t e;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d", $time, a.result_kind);
        errors++;
        return;
      end
      e = expected_results.pop_front();
      if (a.result_kind !== e.result_kind) begin
        $display("%0t: result_kind exp %0d got %0d", $time, e.result_kind, a.result_kind);
        errors++;
      end
      if (a.packet_id_out !== e.packet_id_out) begin
        $display("%0t: packet_id_out exp %0d got %0d", $time, e.packet_id_out,
                 a.packet_id_out);
        errors++;
      end
      if (a.slack_out !== e.slack_out) begin
        $display("%0t: slack_out exp %0d got %0d", $time, $signed(e.slack_out),
                 $signed(a.slack_out));
        errors++;
      end
      if (a.size_out !== e.size_out) begin
        $display("%0t: size_out exp %0d got %0d", $time, e.size_out, a.size_out);
        errors++;
      end
      if (a.bin_index !== e.bin_index) begin
        $display("%0t: bin_index exp %0d got %0d", $time, e.bin_index, a.bin_index);
        errors++;
      end
      if (a.total_bytes !== e.total_bytes) begin
        $display("%0t: total_bytes exp %0d got %0d", $time, e.total_bytes, a.total_bytes);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int max_gap;
  int stall;
  int cycles;
  logic [39:0] now_t;
  slack_queue_scoreboard sb;

  sbpq_req_if req_ch (clk);
  sbpq_resp_if resp_ch (clk);

  slack_binned_priority_queue i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req(req_ch),
    .resp(resp_ch)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request({req_ch.opcode, req_ch.packet_id, req_ch.slack_in,
                         req_ch.size_bytes, req_ch.now_time});
      if (resp_ch.valid && resp_ch.ready)
        sb.check_result({resp_ch.result_kind, resp_ch.packet_id_out, resp_ch.slack_out,
                         resp_ch.size_out, resp_ch.bin_index, resp_ch.total_bytes});
    end
  end

  // The receiver draws a fresh stall after each item it takes.
  always @(posedge clk) begin
    if (resp_ch.valid && resp_ch.ready) stall = $urandom_range(0, max_gap);
    if (stall > 0) begin
      resp_ch.ready <= 1'b0;
      stall--;
    end else begin
      resp_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(input logic op, input logic [11:0] id, input logic [39:0] sl,
                           input logic [15:0] sz, input logic [39:0] nt);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.opcode <= op;
    req_ch.packet_id <= id;
    req_ch.slack_in <= sl;
    req_ch.size_bytes <= sz;
    req_ch.now_time <= nt;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input logic [39:0] tx, input logic [39:0] step,
                            input logic [39:0] cap, input logic [39:0] en,
                            input logic [39:0] ctrl_end);
    logic [39:0] vals[5];
    vals = '{tx, step, cap, en, ctrl_end};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.apply_reg(cfg_idx_t'(i), vals[i]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int enq_pct, input bit small_sizes);
    logic [39:0] sl, nt;
    logic [15:0] sz;
    longint base;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: sl = 40'({$urandom(), $urandom()});
        1: begin
          base = longint'(sb.bound) * $urandom_range(0, 9);
          sl = 40'(base + $signed($urandom_range(0, 4000)) - 2000);
        end
        2: sl = 40'($signed($urandom_range(0, 2000000)) - 1000000);
        default: sl = $urandom_range(0, 1) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
      endcase
      case ($urandom_range(0, 4))
        0: sz = 16'($urandom());
        1: sz = $urandom_range(0, 1) ? 16'(LARGE_PACKET_BYTES) : 16'(LARGE_PACKET_BYTES - 1);
        default: sz = small_sizes ? 16'($urandom_range(0, 1459)) : 16'($urandom());
      endcase
      if ($urandom_range(0, 9) == 0) begin
        nt = 40'({$urandom(), $urandom()});
      end else begin
        now_t = now_t + 40'($urandom_range(0, 2000));
        nt = now_t;
      end
      send_item($urandom_range(0, 99) >= enq_pct, 12'($urandom()), sl, sz, nt);
    end
    drain();
  endtask

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.opcode = 1'b0;
    req_ch.packet_id = '0;
    req_ch.slack_in = '0;
    req_ch.size_bytes = '0;
    req_ch.now_time = '0;
    resp_ch.ready = 1'b0;
    stall = 0;
    cycles = 0;
    max_gap = 0;
    now_t = 40'd5000;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: empty queue, bin edges, and both saturation directions.
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'd0);
    send_item(1'b0, 12'hFFF, 40'h7F_FFFF_FFFF, 16'hFFFF, 40'd1000);
    send_item(1'b0, 12'd1, 40'h80_0000_0000, 16'd0, 40'd0);
    send_item(1'b0, 12'd2, 40'd125000000, 16'd0, 40'd0);
    send_item(1'b0, 12'd3, 40'd125000001, 16'd0, 40'd0);
    send_item(1'b0, 12'd4, 40'd0, 16'd1460, 40'hFF_FFFF_FFFF);
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'hFF_FFFF_FFFF);
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'd5);
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'd7);
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'd0);
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'd0);
    send_item(1'b1, 12'd0, 40'd0, 16'd0, 40'd0);
    drain();

    max_gap = 10;
    random_phase(80, 60, 1'b0);

    // The sender stops here until every result is back.
    max_gap = 0;
    set_config(40'd0, 40'd1000, 40'd2, 40'd0, 40'd0);
    random_phase(100, 60, 1'b0);

    // Every small packet goes to the control bin until it fills and refuses.
    max_gap = 10;
    set_config(40'hFF_FFFF, 40'd1, 40'd64, 40'd1, 40'hFF_FFFF_FFFF);
    random_phase(120, 85, 1'b1);

    max_gap = 5;
    set_config(40'd65536, 40'hFF_FFFF_FFFF, 40'd1, 40'd1, 40'h80_0000_0000);
    random_phase(100, 55, 1'b0);

    max_gap = 10;
    set_config(40'($urandom_range(0, 16777215)), 40'd0, 40'd0, 40'd0, 40'd12345);
    random_phase(80, 60, 1'b0);

    max_gap = 0;
    set_config(40'd52429, 40'd50000, 40'd100, 40'd1, 40'd0);
    random_phase(120, 70, 1'b0);

    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
